@@ hdl/t8cpu_pkg.sv @@
// Shared types and constants for the tiny 8-bit processor step block.
`default_nettype none

package t8cpu_pkg;

    // Fixed field widths of the request and response channels
    localparam int REQ_W  = 2;
    localparam int ADDR_W = 9;
    localparam int DATA_W = 8;
    localparam int STAT_W = 3;

    // Program counter value after reset or a pc reset request
    localparam int PC_RESET = 509;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_PC_RST = 2'd2,
        REQ_STEP   = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_HALT    = 3'd1,
        ST_TOP     = 3'd2,
        ST_ADDR    = 3'd3,
        ST_OPC     = 3'd4,
        ST_HALTED  = 3'd5
    } status_t;

    // Opcodes
    localparam logic [DATA_W-1:0] OP_STA = 8'h0C;  // store A to [hi:lo]
    localparam logic [DATA_W-1:0] OP_LDA = 8'h37;  // A = imm
    localparam logic [DATA_W-1:0] OP_LDB = 8'h38;  // B = imm
    localparam logic [DATA_W-1:0] OP_INC = 8'h53;  // A = A + 1
    localparam logic [DATA_W-1:0] OP_JMP = 8'h5A;  // pc = [hi:lo]
    localparam logic [DATA_W-1:0] OP_BLT = 8'h5B;  // if A < B pc = [hi:lo]
    localparam logic [DATA_W-1:0] OP_BGT = 8'h5D;  // if imm < A pc = [hi:lo]
    localparam logic [DATA_W-1:0] OP_HLT = 8'h64;  // halt

    typedef enum logic [2:0] {
        S_IDLE,   // take next request from the input buffer
        S_MISC,   // finish write, read, pc reset and trivial steps
        S_OPC,    // opcode byte in read data register
        S_OPND,   // operand bytes arriving, one per cycle
        S_EXEC    // execute, write back, hand result to output register
    } state_t;

endpackage

`default_nettype wire

@@ hdl/tiny_8bit_cpu_step_top.sv @@
// Top level of the tiny 8-bit processor step block.
//
// Usage:
//   Requests come in on the s_ channel (valid/ready): write a memory byte, read a
//   memory byte, reset the program counter to 509, or step one instruction.
//   Every request gives exactly one response on the m_ channel (valid/ready)
//   carrying status, read byte, pc, A, B and the halt flag after the request.
//   A one-entry input buffer takes a transfer while the previous request is
//   still in progress; an output register holds the finished response.
// Sequencing:
//   Memory requests, pc reset and steps that fail before the opcode fetch go
//   through S_IDLE and S_MISC. A step goes through S_IDLE, S_OPC, S_OPND while
//   any operand bytes arrive, and S_EXEC, as the single-port program memory gives
//   one byte per cycle, read data registered in the cycle after the address.
// Reset:
//   aresetn (synchronous, active low) empties both buffers, sets pc to 509 and
//   clears A, B and the halt flag. Memory contents are not cleared.
// Stalls:
//   If m_ready is low while the output register is full, the next response
//   waits in its final state with no state update and no memory write until the
//   output register frees up; the input buffer then fills and s_ready drops.
`default_nettype none

module tiny_8bit_cpu_step_top #(
    parameter int MEM_BYTES = 512
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [t8cpu_pkg::REQ_W-1:0]    s_req_type,
    input  logic [t8cpu_pkg::ADDR_W-1:0]   s_mem_addr,
    input  logic [t8cpu_pkg::DATA_W-1:0]   s_mem_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [t8cpu_pkg::STAT_W-1:0]   m_status,
    output logic [t8cpu_pkg::DATA_W-1:0]   m_read_data,
    output logic [t8cpu_pkg::ADDR_W-1:0]   m_pc_now,
    output logic [t8cpu_pkg::DATA_W-1:0]   m_acc_a,
    output logic [t8cpu_pkg::DATA_W-1:0]   m_acc_b,
    output logic                           m_is_halted
);
    import t8cpu_pkg::*;

    localparam int AW  = $clog2(MEM_BYTES);
    localparam int PCW = (AW > ADDR_W) ? AW : ADDR_W;
    localparam int TW  = 2 * DATA_W;
    localparam logic [PCW:0] MEM_TOP = (PCW+1)'(MEM_BYTES);
    localparam logic [TW:0]  TGT_LIM = (TW+1)'(MEM_BYTES);

    // instruction length for the bounds check
    function automatic logic [2:0] op_len(input logic [DATA_W-1:0] op);
        logic [2:0] len;
        unique case (op)
            OP_STA, OP_BLT:         len = 3'd3;
            OP_LDA, OP_LDB, OP_JMP: len = 3'd2;
            OP_INC:                 len = 3'd1;
            OP_BGT:                 len = 3'd4;
            default:                len = 3'd0;
        endcase
        return len;
    endfunction

    // operand bytes to fetch after the opcode
    function automatic logic [1:0] op_nopnd(input logic [DATA_W-1:0] op);
        logic [1:0] n;
        unique case (op)
            OP_STA, OP_JMP, OP_BLT: n = 2'd2;
            OP_LDA, OP_LDB:         n = 2'd1;
            OP_BGT:                 n = 2'd3;
            default:                n = 2'd0;
        endcase
        return n;
    endfunction

    // ---------------- registers ----------------
    state_t              state_reg, state_next;

    logic                in_full_reg;
    req_t                in_req_reg;
    logic [ADDR_W-1:0]   in_addr_reg;
    logic [DATA_W-1:0]   in_data_reg;

    req_t                cur_req_reg;
    logic [ADDR_W-1:0]   cur_addr_reg;
    logic [DATA_W-1:0]   cur_data_reg;

    logic [DATA_W-1:0]   op_reg;
    logic [DATA_W-1:0]   opnd_reg [3];
    logic [1:0]          cnt_reg;
    logic [1:0]          need_reg;

    logic [PCW-1:0]      pc_reg,   pc_next;
    logic [DATA_W-1:0]   a_reg,    a_next;
    logic [DATA_W-1:0]   b_reg,    b_next;
    logic                halt_reg, halt_next;

    logic                m_valid_reg;
    status_t             m_status_reg, m_status_next;
    logic [DATA_W-1:0]   m_read_data_reg, m_read_data_next;
    logic [ADDR_W-1:0]   m_pc_reg;
    logic [DATA_W-1:0]   m_a_reg;
    logic [DATA_W-1:0]   m_b_reg;
    logic                m_halt_reg;

    // program memory, single port, registered read
    logic [DATA_W-1:0]   mem [MEM_BYTES];
    logic [DATA_W-1:0]   mem_rdata_reg;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_a;
    logic [DATA_W-1:0]   mem_wd;

    // ---------------- control signals ----------------
    logic                pop;
    logic                out_free;
    logic                fin;
    logic                fire;
    logic [1:0]          need_c;
    logic [PCW:0]        pc_ext;
    logic                pc_in_range;
    logic                cur_addr_ok;
    logic                in_addr_ok;
    logic [TW-1:0]       tgt;
    logic                tgt_ok;
    logic                top_ok;
    logic                opc_top_ok;

    assign pop      = (state_reg == S_IDLE) && in_full_reg;
    assign s_ready  = !in_full_reg || pop;
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = fin && out_free;

    assign pc_ext      = {1'b0, pc_reg};
    assign pc_in_range = pc_ext < MEM_TOP;
    assign cur_addr_ok = (PCW+1)'(cur_addr_reg) < MEM_TOP;
    assign in_addr_ok  = (PCW+1)'(in_addr_reg) < MEM_TOP;

    assign tgt    = (op_reg == OP_BGT) ? {opnd_reg[1], opnd_reg[2]}
                                       : {opnd_reg[0], opnd_reg[1]};
    assign tgt_ok = {1'b0, tgt} < TGT_LIM;
    assign top_ok = (pc_ext + (PCW+1)'(op_len(op_reg))) < MEM_TOP;
    assign opc_top_ok = (pc_ext + (PCW+1)'(op_len(mem_rdata_reg))) < MEM_TOP;
    assign need_c = opc_top_ok ? op_nopnd(mem_rdata_reg) : 2'd0;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_full_reg) begin
                    if (in_req_reg == REQ_STEP && !halt_reg && pc_in_range) begin
                        state_next = S_OPC;
                    end else begin
                        state_next = S_MISC;
                    end
                end
            end
            S_MISC: begin
                if (fire) begin
                    state_next = S_IDLE;
                end
            end
            S_OPC: begin
                state_next = (need_c != 2'd0) ? S_OPND : S_EXEC;
            end
            S_OPND: begin
                if (cnt_reg + 2'd1 == need_reg) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- datapath and memory control ----------------
    always_comb begin
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_a            = '0;
        mem_wd           = a_reg;
        fin              = 1'b0;
        m_status_next    = ST_OK;
        m_read_data_next = '0;
        pc_next          = pc_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        halt_next        = halt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_full_reg) begin
                    if (in_req_reg == REQ_READ) begin
                        mem_re = in_addr_ok;
                        mem_a  = AW'(in_addr_reg);
                    end else if (in_req_reg == REQ_STEP) begin
                        mem_re = pc_in_range;
                        mem_a  = AW'(pc_reg);
                    end
                end
            end
            S_MISC: begin
                fin = 1'b1;
                unique case (cur_req_reg)
                    REQ_WRITE: begin
                        if (cur_addr_ok) begin
                            mem_we = out_free;
                            mem_a  = AW'(cur_addr_reg);
                            mem_wd = cur_data_reg;
                        end else begin
                            m_status_next = ST_ADDR;
                        end
                    end
                    REQ_READ: begin
                        if (cur_addr_ok) begin
                            m_read_data_next = mem_rdata_reg;
                        end else begin
                            m_status_next = ST_ADDR;
                        end
                    end
                    REQ_PC_RST: begin
                        pc_next   = PCW'(PC_RESET);
                        halt_next = 1'b0;
                    end
                    REQ_STEP: begin
                        // either already halted or opcode fetch past the top
                        if (halt_reg) begin
                            m_status_next = ST_HALTED;
                        end else begin
                            m_status_next = ST_TOP;
                            halt_next     = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_OPC: begin
                if (need_c != 2'd0) begin
                    mem_re = 1'b1;
                    mem_a  = AW'(pc_reg + PCW'(1));
                end
            end
            S_OPND: begin
                if (cnt_reg + 2'd1 != need_reg) begin
                    mem_re = 1'b1;
                    mem_a  = AW'(pc_reg + PCW'(2) + PCW'(cnt_reg));
                end
            end
            S_EXEC: begin
                fin = 1'b1;
                if (op_reg == OP_HLT) begin
                    m_status_next = ST_HALT;
                end else if (op_len(op_reg) == 3'd0) begin
                    m_status_next = ST_OPC;
                end else if (!top_ok) begin
                    m_status_next = ST_TOP;
                end else begin
                    unique case (op_reg)
                        OP_STA: begin
                            if (tgt_ok) begin
                                mem_we  = out_free;
                                mem_a   = AW'(tgt);
                                mem_wd  = a_reg;
                                pc_next = pc_reg + PCW'(3);
                            end else begin
                                m_status_next = ST_ADDR;
                            end
                        end
                        OP_LDA: begin
                            a_next  = opnd_reg[0];
                            pc_next = pc_reg + PCW'(2);
                        end
                        OP_LDB: begin
                            b_next  = opnd_reg[0];
                            pc_next = pc_reg + PCW'(2);
                        end
                        OP_INC: begin
                            a_next  = a_reg + DATA_W'(1);
                            pc_next = pc_reg + PCW'(1);
                        end
                        OP_JMP: begin
                            if (tgt_ok) begin
                                pc_next = PCW'(tgt);
                            end else begin
                                m_status_next = ST_ADDR;
                            end
                        end
                        OP_BLT: begin
                            if (a_reg < b_reg) begin
                                if (tgt_ok) begin
                                    pc_next = PCW'(tgt);
                                end else begin
                                    m_status_next = ST_ADDR;
                                end
                            end else begin
                                pc_next = pc_reg + PCW'(3);
                            end
                        end
                        OP_BGT: begin
                            if (opnd_reg[0] < a_reg) begin
                                if (tgt_ok) begin
                                    pc_next = PCW'(tgt);
                                end else begin
                                    m_status_next = ST_ADDR;
                                end
                            end else begin
                                pc_next = pc_reg + PCW'(4);
                            end
                        end
                        default: m_status_next = ST_OPC;
                    endcase
                end
                // any failing status stops the core with pc left at the opcode
                if (m_status_next != ST_OK) begin
                    halt_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ---------------- memory ----------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_a] <= mem_wd;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_a];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            in_full_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= 2'd0;
            need_reg    <= 2'd0;
            pc_reg      <= PCW'(PC_RESET);
            a_reg       <= '0;
            b_reg       <= '0;
            halt_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_valid && s_ready) begin
                in_full_reg <= 1'b1;
            end else if (pop) begin
                in_full_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == S_OPC) begin
                need_reg <= need_c;
                cnt_reg  <= 2'd0;
            end else if (state_reg == S_OPND) begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            if (fire) begin
                pc_reg   <= pc_next;
                a_reg    <= a_next;
                b_reg    <= b_next;
                halt_reg <= halt_next;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg  <= req_t'(s_req_type);
            in_addr_reg <= s_mem_addr;
            in_data_reg <= s_mem_data;
        end
        if (pop) begin
            cur_req_reg  <= in_req_reg;
            cur_addr_reg <= in_addr_reg;
            cur_data_reg <= in_data_reg;
        end
        if (state_reg == S_OPC) begin
            op_reg <= mem_rdata_reg;
        end
        if (state_reg == S_OPND) begin
            opnd_reg[cnt_reg] <= mem_rdata_reg;
        end
        if (fire) begin
            m_status_reg    <= m_status_next;
            m_read_data_reg <= m_read_data_next;
            m_pc_reg        <= pc_next[ADDR_W-1:0];
            m_a_reg         <= a_next;
            m_b_reg         <= b_next;
            m_halt_reg      <= halt_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_read_data = m_read_data_reg;
    assign m_pc_now    = m_pc_reg;
    assign m_acc_a     = m_a_reg;
    assign m_acc_b     = m_b_reg;
    assign m_is_halted = m_halt_reg;

    // ---------------- assertions ----------------
    // memory is written only when the response is handed over
    a_we_on_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> fire)
        else $error("memory write without response transfer");

    // a response appears only from a finishing request
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && !fire) |=> !m_valid_reg)
        else $error("response valid without a finished request");

    // a step on a halted core leaves the program counter alone
    a_halted_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && state_reg == S_MISC && cur_req_reg == REQ_STEP && halt_reg)
        |=> (pc_reg == $past(pc_reg) && halt_reg))
        else $error("halted step changed pc");

    // operand counter stays below the operand count
    a_opnd_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OPND) |-> (cnt_reg < need_reg))
        else $error("operand counter overrun");

    // no new request starts while the output stage still owes a response
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && !fire) |=> (state_reg == S_EXEC))
        else $error("execute state left without a response");

endmodule

`default_nettype wire

@@ test/tiny_8bit_cpu_step_top_test.sv @@
// Self-checking testbench for the tiny 8-bit processor step block.
`timescale 1ns / 1ps

module tiny_8bit_cpu_step_top_test;
    import t8cpu_pkg::*;

    localparam int MEM_BYTES  = 512;
    localparam int ITEM_TOTAL = 1750;   // stimulus stops once this many transfers went in
    localparam int PHASE_LEN  = 150;    // transfers per idling phase in the random part

    // One response as seen on the m_ channel
    typedef struct {
        status_t           status;
        logic [DATA_W-1:0] read_data;
        logic [ADDR_W-1:0] pc_now;
        logic [DATA_W-1:0] acc_a;
        logic [DATA_W-1:0] acc_b;
        logic              is_halted;
    } cpu_resp_t;

    // Directed stimulus row with its hand-written response
    typedef struct {
        req_t              kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        cpu_resp_t         want;
    } dir_row_t;

    // Every input starts at a known value
    logic              aclk       = 1'b0;
    logic              aresetn    = 1'b0;
    logic              s_valid    = 1'b0;
    logic              s_ready;
    logic [REQ_W-1:0]  s_req_type = '0;
    logic [ADDR_W-1:0] s_mem_addr = '0;
    logic [DATA_W-1:0] s_mem_data = '0;
    logic              m_valid;
    logic              m_ready    = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic [DATA_W-1:0] m_read_data;
    logic [ADDR_W-1:0] m_pc_now;
    logic [DATA_W-1:0] m_acc_a;
    logic [DATA_W-1:0] m_acc_b;
    logic              m_is_halted;

    // Sideband that travels with each transfer: use the typed response, not the predictor
    logic              item_typed = 1'b0;
    cpu_resp_t         item_want;

    // Shadow copy of the core; memory is fully written before any step or read
    logic [DATA_W-1:0] shadow_mem [MEM_BYTES];
    int                shadow_pc     = PC_RESET;
    logic [DATA_W-1:0] shadow_a      = '0;
    logic [DATA_W-1:0] shadow_b      = '0;
    logic              shadow_halted = 1'b0;

    cpu_resp_t pending_responses[$];
    dir_row_t  directed[$];

    int idle_pct   = 0;   // sender: chance of an idle cycle before a transfer
    int stall_pct  = 0;   // receiver: chance of m_ready low in a cycle
    int sent_items = 0;
    int steps_sent = 0;
    int checked    = 0;
    int halts_seen = 0;
    int errors     = 0;

    tiny_8bit_cpu_step_top #(
        .MEM_BYTES(MEM_BYTES)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_mem_addr  (s_mem_addr),
        .s_mem_data  (s_mem_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_read_data (m_read_data),
        .m_pc_now    (m_pc_now),
        .m_acc_a     (m_acc_a),
        .m_acc_b     (m_acc_b),
        .m_is_halted (m_is_halted)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Operand fetch; anything past the top of memory reads as zero
    function automatic logic [DATA_W-1:0] byte_at(int addr);
        return (addr < MEM_BYTES) ? shadow_mem[addr] : '0;
    endfunction

    // Big-endian 16-bit jump/store address starting at addr
    function automatic int target_at(int addr);
        return int'({byte_at(addr), byte_at(addr + 1)});
    endfunction

    // Execute the instruction at the shadow pc. On any non-OK status nothing
    // is committed and the pc stays on the opcode.
    function automatic status_t step_core();
        int                pc;
        int                tgt;
        logic [DATA_W-1:0] op;
        pc = shadow_pc;
        if (pc >= MEM_BYTES) return ST_TOP;
        op = shadow_mem[pc];
        case (op)
            OP_STA: begin
                if (pc + 3 >= MEM_BYTES) return ST_TOP;
                tgt = target_at(pc + 1);
                if (tgt >= MEM_BYTES) return ST_ADDR;
                shadow_mem[tgt] = shadow_a;
                shadow_pc = pc + 3;
            end
            OP_LDA, OP_LDB: begin
                if (pc + 2 >= MEM_BYTES) return ST_TOP;
                if (op == OP_LDA) shadow_a = byte_at(pc + 1);
                else shadow_b = byte_at(pc + 1);
                shadow_pc = pc + 2;
            end
            OP_INC: begin
                if (pc + 1 >= MEM_BYTES) return ST_TOP;
                shadow_a = shadow_a + 8'd1;
                shadow_pc = pc + 1;
            end
            OP_JMP: begin
                // bounds rule uses length 2 here even though it reads two operands
                if (pc + 2 >= MEM_BYTES) return ST_TOP;
                tgt = target_at(pc + 1);
                if (tgt >= MEM_BYTES) return ST_ADDR;
                shadow_pc = tgt;
            end
            OP_BLT: begin
                if (pc + 3 >= MEM_BYTES) return ST_TOP;
                if (shadow_a < shadow_b) begin
                    tgt = target_at(pc + 1);
                    if (tgt >= MEM_BYTES) return ST_ADDR;
                    shadow_pc = tgt;
                end else begin
                    shadow_pc = pc + 3;
                end
            end
            OP_BGT: begin
                if (pc + 4 >= MEM_BYTES) return ST_TOP;
                if (byte_at(pc + 1) < shadow_a) begin
                    tgt = target_at(pc + 2);
                    if (tgt >= MEM_BYTES) return ST_ADDR;
                    shadow_pc = tgt;
                end else begin
                    shadow_pc = pc + 4;
                end
            end
            OP_HLT: return ST_HALT;
            default: return ST_OPC;
        endcase
        return ST_OK;
    endfunction

    // Apply one request to the shadow core and return the response it gives
    function automatic cpu_resp_t cpu_after_request(req_t kind, logic [ADDR_W-1:0] addr,
                                                    logic [DATA_W-1:0] data);
        cpu_resp_t r;
        r.status    = ST_OK;
        r.read_data = '0;
        case (kind)
            REQ_WRITE: begin
                if (int'(addr) < MEM_BYTES) shadow_mem[addr] = data;
                else r.status = ST_ADDR;
            end
            REQ_READ: begin
                if (int'(addr) < MEM_BYTES) r.read_data = shadow_mem[addr];
                else r.status = ST_ADDR;
            end
            REQ_PC_RST: begin
                shadow_pc     = PC_RESET;
                shadow_halted = 1'b0;
            end
            default: begin
                if (shadow_halted) begin
                    r.status = ST_HALTED;
                end else begin
                    r.status = step_core();
                    if (r.status != ST_OK) shadow_halted = 1'b1;
                end
            end
        endcase
        r.pc_now    = ADDR_W'(shadow_pc);
        r.acc_a     = shadow_a;
        r.acc_b     = shadow_b;
        r.is_halted = shadow_halted;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errors++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Sample both channels at the edge. Predict on each input transfer and
    // compare each output transfer with the oldest waiting response.
    always @(posedge aclk) begin
        cpu_resp_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = cpu_after_request(req_t'(s_req_type), s_mem_addr, s_mem_data);
                if (item_typed) want = item_want;
                pending_responses.push_back(want);
                if (s_req_type == REQ_STEP) steps_sent++;
            end
            if (m_valid && m_ready) begin
                if (pending_responses.size() == 0) begin
                    errors++;
                    $error("response transfer with no request waiting");
                end else begin
                    want = pending_responses.pop_front();
                    check_field("status",    want.status,    m_status);
                    check_field("read_data", want.read_data, m_read_data);
                    check_field("pc_now",    want.pc_now,    m_pc_now);
                    check_field("acc_a",     want.acc_a,     m_acc_a);
                    check_field("acc_b",     want.acc_b,     m_acc_b);
                    check_field("is_halted", want.is_halted, m_is_halted);
                    checked++;
                    if (want.status != ST_OK && want.status != ST_HALTED) halts_seen++;
                end
            end
        end
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Present one request and hold it until the transfer. Called from code that has
    // just waited on the rising clock; s_valid stays high between transfers unless the sender idles first.
    task automatic send_request(req_t kind, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_mem_addr <= addr;
        s_mem_data <= data;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    // Branch or store address: mostly inside the program, some anywhere in
    // memory, some at or past the top so the core flags a bad address.
    function automatic logic [15:0] branch_target(int base, int span);
        int k;
        int t;
        k = $urandom_range(99);
        if (k < 75) begin
            t = base + $urandom_range(span);
            if (t > MEM_BYTES - 1) t = MEM_BYTES - 1;
            return 16'(t);
        end
        if (k < 92) return 16'($urandom_range(MEM_BYTES - 1));
        return {8'($urandom_range(2, 255)), 8'($urandom)};
    endfunction

    // Write a short random program, point the boot jump at it, reset the pc
    // and run it for a while with the odd read or write mixed in.
    task automatic run_program();
        logic [DATA_W-1:0] code[$];
        logic [15:0]       tgt;
        logic [DATA_W-1:0] op;
        int                base;
        int                n_ops;
        int                n_steps;
        int                span;
        int                k;
        // a few programs sit right under the top to hit the bounds rule
        base    = ($urandom_range(9) == 0) ? $urandom_range(480, MEM_BYTES - 4)
                                           : $urandom_range(0, 470);
        n_ops   = $urandom_range(1, 8);
        span    = 3 * n_ops;
        for (int i = 0; i < n_ops; i++) begin
            k = $urandom_range(99);
            if (k < 12) begin
                tgt = branch_target(0, MEM_BYTES - 1);
                code.push_back(OP_STA);
                code.push_back(tgt[15:8]);
                code.push_back(tgt[7:0]);
            end else if (k < 26) begin
                code.push_back(OP_LDA);
                code.push_back(8'($urandom));
            end else if (k < 40) begin
                code.push_back(OP_LDB);
                code.push_back(8'($urandom));
            end else if (k < 58) begin
                code.push_back(OP_INC);
            end else if (k < 66) begin
                tgt = branch_target(base, span);
                code.push_back(OP_JMP);
                code.push_back(tgt[15:8]);
                code.push_back(tgt[7:0]);
            end else if (k < 80) begin
                tgt = branch_target(base, span);
                code.push_back(OP_BLT);
                code.push_back(tgt[15:8]);
                code.push_back(tgt[7:0]);
            end else if (k < 94) begin
                tgt = branch_target(base, span);
                code.push_back(OP_BGT);
                code.push_back(8'($urandom));
                code.push_back(tgt[15:8]);
                code.push_back(tgt[7:0]);
            end else if (k < 97) begin
                code.push_back(OP_HLT);
            end else begin
                op = 8'($urandom);
                case (op)
                    OP_STA, OP_LDA, OP_LDB, OP_INC, OP_JMP, OP_BLT, OP_BGT, OP_HLT: op = 8'h00;
                    default: ;
                endcase
                code.push_back(op);
            end
        end
        for (int i = 0; i < code.size() && base + i < MEM_BYTES; i++)
            send_request(REQ_WRITE, ADDR_W'(base + i), code[i]);
        // now and then skip the boot jump and pc reset: steps go on from wherever
        if ($urandom_range(9) != 0) begin
            send_request(REQ_WRITE, ADDR_W'(PC_RESET), OP_JMP);
            send_request(REQ_WRITE, ADDR_W'(PC_RESET + 1), 8'(base >> 8));
            send_request(REQ_WRITE, ADDR_W'(PC_RESET + 2), 8'(base));
            send_request(REQ_PC_RST, ADDR_W'($urandom), 8'($urandom));
        end
        n_steps = $urandom_range(n_ops, 3 * n_ops + 4);
        repeat (n_steps) begin
            k = $urandom_range(99);
            if (k < 8) send_request(REQ_READ, ADDR_W'($urandom), 8'($urandom));
            else if (k < 11) send_request(REQ_WRITE, ADDR_W'($urandom), 8'($urandom));
            send_request(REQ_STEP, ADDR_W'($urandom), 8'($urandom));
        end
    endtask

    function automatic dir_row_t row(req_t kind, int addr, int data, status_t st, int rd,
                                     int pc, int a, int b, bit h);
        dir_row_t r;
        r.kind           = kind;
        r.addr           = ADDR_W'(addr);
        r.data           = DATA_W'(data);
        r.want.status    = st;
        r.want.read_data = DATA_W'(rd);
        r.want.pc_now    = ADDR_W'(pc);
        r.want.acc_a     = DATA_W'(a);
        r.want.acc_b     = DATA_W'(b);
        r.want.is_halted = h;
        return r;
    endfunction

    initial begin
        // Directed table. Memory is fully loaded before it runs and the core
        // sits at pc 509 with A = B = 0, so every response can be typed in.
        //                      req         addr  data   status     rd    pc    A     B   h
        directed.push_back(row(REQ_WRITE,  509, 8'h37, ST_OK,     0,    509,  0,    0,  0));
        directed.push_back(row(REQ_WRITE,  510, 8'hFF, ST_OK,     0,    509,  0,    0,  0));
        // load A with the largest byte
        directed.push_back(row(REQ_STEP,   0,   0,     ST_OK,     0,    511,  8'hFF, 0, 0));
        directed.push_back(row(REQ_WRITE,  511, 8'h53, ST_OK,     0,    511,  8'hFF, 0, 0));
        // increment on the last byte runs off the top
        directed.push_back(row(REQ_STEP,   0,   0,     ST_TOP,    0,    511,  8'hFF, 0, 1));
        // stepping a halted core changes nothing
        directed.push_back(row(REQ_STEP,   0,   0,     ST_HALTED, 0,    511,  8'hFF, 0, 1));
        directed.push_back(row(REQ_READ,   511, 0,     ST_OK,     8'h53, 511, 8'hFF, 0, 1));
        // pc reset keeps A and B and clears the halt
        directed.push_back(row(REQ_PC_RST, 0,   0,     ST_OK,     0,    509,  8'hFF, 0, 0));
        directed.push_back(row(REQ_WRITE,  509, 8'h53, ST_OK,     0,    509,  8'hFF, 0, 0));
        // A wraps from FF to 00
        directed.push_back(row(REQ_STEP,   0,   0,     ST_OK,     0,    510,  0,    0,  0));
        directed.push_back(row(REQ_WRITE,  510, 8'h64, ST_OK,     0,    510,  0,    0,  0));
        // halt opcode, pc stays on it
        directed.push_back(row(REQ_STEP,   0,   0,     ST_HALT,   0,    510,  0,    0,  1));
        directed.push_back(row(REQ_PC_RST, 0,   0,     ST_OK,     0,    509,  0,    0,  0));
        directed.push_back(row(REQ_WRITE,  509, 8'hFF, ST_OK,     0,    509,  0,    0,  0));
        // unknown opcode
        directed.push_back(row(REQ_STEP,   0,   0,     ST_OPC,    0,    509,  0,    0,  1));
        directed.push_back(row(REQ_PC_RST, 0,   0,     ST_OK,     0,    509,  0,    0,  0));
        directed.push_back(row(REQ_WRITE,  509, 8'h5A, ST_OK,     0,    509,  0,    0,  0));
        directed.push_back(row(REQ_WRITE,  510, 8'h02, ST_OK,     0,    509,  0,    0,  0));
        // jump to 0x253, past the end of memory
        directed.push_back(row(REQ_STEP,   0,   0,     ST_ADDR,   0,    509,  0,    0,  1));
        directed.push_back(row(REQ_PC_RST, 0,   0,     ST_OK,     0,    509,  0,    0,  0));
        directed.push_back(row(REQ_WRITE,  510, 8'h01, ST_OK,     0,    509,  0,    0,  0));
        directed.push_back(row(REQ_WRITE,  511, 8'hFF, ST_OK,     0,    509,  0,    0,  0));
        // jump to the very last byte
        directed.push_back(row(REQ_STEP,   0,   0,     ST_OK,     0,    511,  0,    0,  0));
        directed.push_back(row(REQ_WRITE,  0,   8'h80, ST_OK,     0,    511,  0,    0,  0));
        directed.push_back(row(REQ_READ,   0,   0,     ST_OK,     8'h80, 511, 0,    0,  0));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Load every memory byte first so no step or read ever sees an unwritten one
        idle_pct  = 19;
        stall_pct = 19;
        for (int a = 0; a < MEM_BYTES; a++)
            send_request(REQ_WRITE, ADDR_W'(a), 8'($urandom));

        idle_pct  = 0;
        stall_pct = 0;
        foreach (directed[i]) begin
            item_typed <= 1'b1;
            item_want  <= directed[i].want;
            send_request(directed[i].kind, directed[i].addr, directed[i].data);
        end
        item_typed <= 1'b0;

        // Random part: mostly well-formed programs, the rest raw noise.
        // Idling phases rotate: none, sender only, receiver only, both.
        while (sent_items < ITEM_TOTAL) begin
            case ((sent_items / PHASE_LEN) % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            if ($urandom_range(99) < 80) begin
                run_program();
            end else begin
                repeat ($urandom_range(1, 6))
                    send_request(req_t'($urandom_range(3)), ADDR_W'($urandom), 8'($urandom));
            end
        end
        s_valid   <= 1'b0;
        stall_pct = 0;

        // Drain, then give the block time to show any stray response
        @(posedge aclk);
        while (pending_responses.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d requests (%0d instruction steps); %0d responses compared,",
                 sent_items, steps_sent, checked);
        $display("%0d of them stopping the core on halt, top, address or opcode.", halts_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hang guard: a correct run needs well under a tenth of this
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
